// ===== hw/rtl/pvb_pkg.sv =====
// Shared types and constants for the point-versus-box table check.
// Holds the command codes, the back-end state type and the default sizes.
// Depends on nothing.
`timescale 1ns / 1ps

package pvb_pkg;

   // Default sizes handed to the top-level parameters.
   localparam int MAX_BOXES_DEF  = 64;
   localparam int COORD_BITS_DEF = 32;

   // Width of the safety margin register.
   localparam int MARGIN_BITS = 31;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Operation codes as they arrive on the request port.
   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_CHECK  = 2'd2
   } op_type;

   // Classified command carried through the queue.
   localparam int CMD_BITS = 2;
   typedef enum logic [CMD_BITS-1:0] {
      CMD_NOP    = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_APPEND = 2'd2,
      CMD_CHECK  = 2'd3
   } cmd_type;

   // Back-end sequencer states.
   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_WALK = 1'b1
   } back_state_type;

endpackage

// ===== hw/rtl/pvb_queue.sv =====
// Short queue of classified command words between the front and back ends.
// Depends on pvb_pkg for the depth and pointer widths.
`timescale 1ns / 1ps

module pvb_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   import pvb_pkg::*;

   logic [WIDTH-1:0]     entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill-count update; pointers wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage for queued words needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/pvb_front.sv =====
// Front end: takes request words, classifies the operation and packs a queue word.
// Depends on pvb_pkg for the operation and command codes.
`timescale 1ns / 1ps

module pvb_front #(
   parameter int COORD_BITS = pvb_pkg::COORD_BITS_DEF
) (
   input  logic                                       start,
   output logic                                       busy,
   input  logic [1:0]                                 req_operation,
   input  logic signed [COORD_BITS-1:0]               req_coord_x,
   input  logic signed [COORD_BITS-1:0]               req_coord_y,
   input  logic signed [COORD_BITS-1:0]               req_coord_z,
   input  logic signed [COORD_BITS-1:0]               req_upper_x,
   input  logic signed [COORD_BITS-1:0]               req_upper_y,
   input  logic signed [COORD_BITS-1:0]               req_upper_z,
   input  logic                                       queue_full,
   output logic                                       push,
   output logic [pvb_pkg::CMD_BITS+6*COORD_BITS-1:0]  push_data
);
   import pvb_pkg::*;

   cmd_type                       cmd;
   logic signed [COORD_BITS-1:0]  up_x, up_y, up_z;

   assign busy = queue_full;
   assign push = start && !queue_full;

   // Map the request code to a command; the unused code becomes a no-op.
   always_comb begin
      unique case (req_operation)
         OP_CLEAR:  cmd = CMD_CLEAR;
         OP_APPEND: cmd = CMD_APPEND;
         OP_CHECK:  cmd = CMD_CHECK;
         default:   cmd = CMD_NOP;
      endcase
   end

   // Upper bounds only matter for an append.
   assign up_x = (cmd == CMD_APPEND) ? req_upper_x : '0;
   assign up_y = (cmd == CMD_APPEND) ? req_upper_y : '0;
   assign up_z = (cmd == CMD_APPEND) ? req_upper_z : '0;

   // Queue word layout, low to high: min x, y, z, max x, y, z, command.
   assign push_data = {cmd, up_z, up_y, up_x, req_coord_z, req_coord_y, req_coord_x};

endmodule

// ===== hw/rtl/pvb_back.sv =====
// Back end: holds the box table and margin, executes queued commands, drives results.
// Depends on pvb_pkg for command codes, state type and margin width.
`timescale 1ns / 1ps

module pvb_back #(
   parameter int MAX_BOXES  = pvb_pkg::MAX_BOXES_DEF,
   parameter int COORD_BITS = pvb_pkg::COORD_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       queue_empty,
   input  logic [pvb_pkg::CMD_BITS+6*COORD_BITS-1:0]  pop_data,
   output logic                                       pop,
   input  logic                                       csr_valid,
   input  logic [pvb_pkg::MARGIN_BITS-1:0]            csr_safety_margin,
   output logic                                       rsp_valid,
   output logic                                       rsp_collides,
   output logic                                       rsp_status
);
   import pvb_pkg::*;

   localparam int BoxBits  = 6 * COORD_BITS;
   localparam int CntBits  = $clog2(MAX_BOXES + 1);
   localparam int IdxBits  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   // Grown bounds need room for a coordinate plus the full margin.
   localparam int CalcBits = ((COORD_BITS > MARGIN_BITS) ? COORD_BITS : MARGIN_BITS) + 2;

   logic [BoxBits-1:0]           box_mem [MAX_BOXES];
   logic [BoxBits-1:0]           rd_data_ff;
   logic                         rd_vld_ff, rd_vld_in;
   logic                         rd_en, wr_en;

   back_state_type               state_ff, state_in;
   logic [CntBits-1:0]           cnt_ff, cnt_in;
   logic [CntBits-1:0]           idx_ff, idx_in;
   logic                         hit_ff, hit_in;
   logic [3*COORD_BITS-1:0]      pt_ff, pt_in;
   logic [MARGIN_BITS-1:0]       margin_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_coll_ff, rsp_coll_in;
   logic                         rsp_stat_ff, rsp_stat_in;

   cmd_type                      cmd;
   logic signed [CalcBits-1:0]   margin_ext;
   logic [2:0]                   axis_hit;
   logic                         box_hit;

   assign cmd        = cmd_type'(pop_data[BoxBits +: CMD_BITS]);
   assign margin_ext = signed'(CalcBits'(margin_ff));

   // Per-axis inclusive test of the point against the grown bounds of the entry just read.
   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic signed [COORD_BITS-1:0] p_c, lo_c, hi_c;
      logic signed [CalcBits-1:0]   p_w, lo_w, hi_w;
      assign p_c  = signed'(pt_ff[a*COORD_BITS +: COORD_BITS]);
      assign lo_c = signed'(rd_data_ff[a*COORD_BITS +: COORD_BITS]);
      assign hi_c = signed'(rd_data_ff[(a+3)*COORD_BITS +: COORD_BITS]);
      assign p_w  = CalcBits'(p_c);
      assign lo_w = CalcBits'(lo_c);
      assign hi_w = CalcBits'(hi_c);
      assign axis_hit[a] = (p_w >= lo_w - margin_ext) && (p_w <= hi_w + margin_ext);
   end
   assign box_hit = &axis_hit;

   // Sequencer: commands answer from idle, but a check of a non-empty table walks it.
   always_comb begin
      state_in     = state_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      pt_in        = pt_ff;
      rsp_valid_in = 1'b0;
      rsp_coll_in  = 1'b0;
      rsp_stat_in  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               unique case (cmd)
                  CMD_CLEAR: begin
                     cnt_in       = '0;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (cnt_ff == CntBits'(MAX_BOXES)) begin
                        rsp_stat_in = 1'b1;
                     end else begin
                        wr_en  = 1'b1;
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  CMD_CHECK: begin
                     if (cnt_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        pt_in    = pop_data[3*COORD_BITS-1:0];
                        idx_in   = '0;
                        hit_in   = 1'b0;
                        state_in = BK_WALK;
                     end
                  end
                  CMD_NOP: begin
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         BK_WALK: begin
            if (idx_ff < cnt_ff) begin
               rd_en  = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
            if (rd_vld_ff && box_hit) begin
               hit_in = 1'b1;
            end
            // All entries read and the last one compared.
            if ((idx_ff == cnt_ff) && !rd_vld_ff) begin
               rsp_valid_in = 1'b1;
               rsp_coll_in  = hit_ff;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign rd_vld_in = rd_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         margin_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            margin_ff <= csr_safety_margin;
         end
      end
   end

   // Walk bookkeeping and result payload.
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      hit_ff      <= hit_in;
      pt_ff       <= pt_in;
      rsp_coll_ff <= rsp_coll_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   // Box table: one write port for appends, one registered read port for the walk.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         box_mem[cnt_ff[IdxBits-1:0]] <= pop_data[BoxBits-1:0];
      end
      if (rd_en) begin
         rd_data_ff <= box_mem[idx_ff[IdxBits-1:0]];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_collides = rsp_coll_ff;
   assign rsp_status   = rsp_stat_ff;

endmodule

// ===== hw/rtl/point_vs_box_table_check.sv =====
// Top level of the point-versus-box table check.
// Depends on pvb_pkg, pvb_front, pvb_queue and pvb_back.
`timescale 1ns / 1ps

// Each word presented with start while busy is low gets exactly one result, in order,
// shown for a single cycle with rsp_valid; the receiver cannot stall it, so it must
// take every result as it appears. A two-entry queue lets the front end take new words
// while the back end works. Clear, append and the unused code answer straight from idle
// once the back end takes them, and so does a check of an empty table. Any other check
// takes the word, then reads each stored box, one box per cycle, from the single table
// read port, compares the last box read and answers. An append to a full table stores
// nothing and answers with rsp_status set. The safety margin is written through the csr
// port, which is always ready; the user must write it only while the block is idle, as
// the block itself does not enforce this.
module point_vs_box_table_check #(
   parameter int MAX_BOXES  = pvb_pkg::MAX_BOXES_DEF,
   parameter int COORD_BITS = pvb_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_operation,
   input  logic signed [COORD_BITS-1:0]      req_coord_x,
   input  logic signed [COORD_BITS-1:0]      req_coord_y,
   input  logic signed [COORD_BITS-1:0]      req_coord_z,
   input  logic signed [COORD_BITS-1:0]      req_upper_x,
   input  logic signed [COORD_BITS-1:0]      req_upper_y,
   input  logic signed [COORD_BITS-1:0]      req_upper_z,
   output logic                              rsp_valid,
   output logic                              rsp_collides,
   output logic                              rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pvb_pkg::MARGIN_BITS-1:0]   csr_safety_margin
);
   import pvb_pkg::*;

   localparam int WordBits = CMD_BITS + 6 * COORD_BITS;

   logic                push, pop, q_full, q_empty;
   logic [WordBits-1:0] push_word, pop_word;

   // The margin register takes a write on any cycle.
   assign csr_ready = 1'b1;

   pvb_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_coord_x   (req_coord_x),
      .req_coord_y   (req_coord_y),
      .req_coord_z   (req_coord_z),
      .req_upper_x   (req_upper_x),
      .req_upper_y   (req_upper_y),
      .req_upper_z   (req_upper_z),
      .queue_full    (q_full),
      .push          (push),
      .push_data     (push_word)
   );

   pvb_queue #(
      .WIDTH (WordBits)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_word),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_word),
      .empty     (q_empty)
   );

   pvb_back #(
      .MAX_BOXES  (MAX_BOXES),
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (q_empty),
      .pop_data          (pop_word),
      .pop               (pop),
      .csr_valid         (csr_valid && csr_ready),
      .csr_safety_margin (csr_safety_margin),
      .rsp_valid         (rsp_valid),
      .rsp_collides      (rsp_collides),
      .rsp_status        (rsp_status)
   );

endmodule

// ===== hw/rtl/pvb_checker.sv =====
// Port-level checks for the point-versus-box table check, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module pvb_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_collides,
   input logic rsp_status
);

   // Words taken but not yet answered.
   logic [3:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff;
      if ((start && !busy) && !rsp_valid) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_valid && !(start && !busy)) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A full-table append never reports a collision.
   a_status_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> !rsp_collides)
      else $error("status and collides both set");

   // No result appears without a word waiting for it.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 4'd0))
      else $error("result without an outstanding word");

   // Reset leaves no result on the port and the queue open.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !busy))
      else $error("result or busy right after reset");

   // Busy only rises while words are outstanding.
   a_busy_pending: assert property (@(posedge clock) disable iff (reset)
      busy |-> (pending_ff >= 4'd2))
      else $error("busy with too few outstanding words");

endmodule

bind point_vs_box_table_check pvb_checker u_pvb_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_collides (rsp_collides),
   .rsp_status   (rsp_status)
);

// ===== bench/point_vs_box_table_check_tb.sv =====
// Self-checking bench for the point-versus-box table check: clears, appends and point checks
// go in, and every one-cycle answer is compared with a model kept inside this file.
// Depends on pvb_pkg and point_vs_box_table_check.
`timescale 1ns / 1ps

module point_vs_box_table_check_tb;
   import pvb_pkg::*;

   localparam int COORD_W     = COORD_BITS_DEF;
   localparam int BOX_LIMIT   = MAX_BOXES_DEF;
   localparam int MARGIN_W    = MARGIN_BITS;
   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 9;
   localparam int PHASE_WORDS = 500;
   localparam int QUIET_LIMIT = 4000;

   // Code 3 is the unused code, which the block turns into a no-op; it must answer with all zeros.
   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef logic signed [COORD_W-1:0] coord_type;

   localparam coord_type MIN_COORD = {1'b1, {(COORD_W-1){1'b0}}};
   localparam coord_type MAX_COORD = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type UNIT      = coord_type'(32'sh0001_0000);

   typedef struct {
      logic [1:0] op;
      coord_type  lo_x, lo_y, lo_z;
      coord_type  hi_x, hi_y, hi_z;
   } command_word_type;

   typedef struct {
      logic collides;
      logic status;
   } answer_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [1:0] req_operation;
   coord_type req_coord_x, req_coord_y, req_coord_z;
   coord_type req_upper_x, req_upper_y, req_upper_z;
   logic rsp_valid;
   logic rsp_collides;
   logic rsp_status;
   logic csr_valid;
   logic csr_ready;
   logic [MARGIN_W-1:0] csr_safety_margin;

   point_vs_box_table_check dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .req_coord_z       (req_coord_z),
      .req_upper_x       (req_upper_x),
      .req_upper_y       (req_upper_y),
      .req_upper_z       (req_upper_z),
      .rsp_valid         (rsp_valid),
      .rsp_collides      (rsp_collides),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_safety_margin (csr_safety_margin)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Words waiting to be sent and answers waiting to come back.
   command_word_type pending_words[$];
   answer_type       expected_answers[$];

   // Shadow of the obstacle table and the margin register.
   coord_type           shadow_lo[BOX_LIMIT][3];
   coord_type           shadow_hi[BOX_LIMIT][3];
   int unsigned         shadow_count;
   logic [MARGIN_W-1:0] margin_now;

   int sender_idle_pct;
   int words_queued;
   int mismatch_count;
   int quiet_cycles;
   int margins_written;
   int words_sent, checks_sent, hits_seen, appends_sent, full_refusals, clears_sent, spares_sent;

   // True when p lies within [lo - m, hi + m]; one extra bit keeps the bounds from wrapping.
   function automatic logic in_grown(input coord_type p, input coord_type lo,
                                     input coord_type hi, input logic [MARGIN_W-1:0] m);
      logic signed [COORD_W:0] p_w, lo_w, hi_w, m_w;
      p_w = p;
      lo_w = lo;
      hi_w = hi;
      m_w = '0;
      m_w[MARGIN_W-1:0] = m;
      return (p_w >= lo_w - m_w) && (p_w <= hi_w + m_w);
   endfunction

   // Applies one accepted word to the shadow table and returns the answer it must produce.
   function automatic answer_type apply_word(input command_word_type w);
      answer_type ans;
      coord_type  pt[3];
      ans.collides = 1'b0;
      ans.status = 1'b0;
      pt[0] = w.lo_x;
      pt[1] = w.lo_y;
      pt[2] = w.lo_z;
      case (w.op)
         OP_CLEAR: shadow_count = 0;
         OP_APPEND: begin
            if (shadow_count >= BOX_LIMIT) begin
               ans.status = 1'b1;
            end else begin
               shadow_lo[shadow_count] = pt;
               shadow_hi[shadow_count][0] = w.hi_x;
               shadow_hi[shadow_count][1] = w.hi_y;
               shadow_hi[shadow_count][2] = w.hi_z;
               shadow_count++;
            end
         end
         OP_CHECK: begin
            for (int k = 0; k < shadow_count; k++) begin
               if (in_grown(pt[0], shadow_lo[k][0], shadow_hi[k][0], margin_now) &&
                   in_grown(pt[1], shadow_lo[k][1], shadow_hi[k][1], margin_now) &&
                   in_grown(pt[2], shadow_lo[k][2], shadow_hi[k][2], margin_now))
                  ans.collides = 1'b1;
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   // Coordinates mix the extremes, full-range values and small values near the origin.
   function automatic coord_type random_coord();
      int near;
      near = int'($urandom_range(0, 1 << 20)) - (1 << 19);
      case ($urandom_range(0, 9))
         0: return MIN_COORD;
         1: return MAX_COORD;
         2: return '0;
         3: return '1;
         4, 5: return coord_type'($urandom);
         default: return coord_type'(near);
      endcase
   endfunction

   // Picks a value on or just past a grown bound of one axis, in its middle, or at random.
   function automatic coord_type aim_axis(input coord_type lo, input coord_type hi,
                                          input logic [MARGIN_W-1:0] m);
      logic signed [COORD_W+1:0] lo_w, hi_w, m_w, target;
      lo_w = lo;
      hi_w = hi;
      m_w = '0;
      m_w[MARGIN_W-1:0] = m;
      case ($urandom_range(0, 5))
         0: target = lo_w - m_w;
         1: target = lo_w - m_w - 1;
         2: target = hi_w + m_w;
         3: target = hi_w + m_w + 1;
         4: target = (lo_w + hi_w) >>> 1;
         default: return random_coord();
      endcase
      // Fall back to a random value when the target lies outside the coordinate range.
      if (target != {{2{target[COORD_W-1]}}, target[COORD_W-1:0]})
         return random_coord();
      return target[COORD_W-1:0];
   endfunction

   task automatic queue_word(input logic [1:0] op, input coord_type x, input coord_type y,
                             input coord_type z, input coord_type ux, input coord_type uy,
                             input coord_type uz);
      command_word_type w;
      w.op = op;
      w.lo_x = x;
      w.lo_y = y;
      w.lo_z = z;
      w.hi_x = ux;
      w.hi_y = uy;
      w.hi_z = uz;
      pending_words.push_back(w);
      words_queued++;
   endtask

   // A scene is a clear, a run of appends and a run of checks aimed mostly at the stored
   // boxes, with the odd random word mixed in.
   task automatic queue_scene(input int n_boxes, input int n_probes);
      coord_type s_lo[BOX_LIMIT][3];
      coord_type s_hi[BOX_LIMIT][3];
      coord_type lo_a[3], hi_a[3], pt[3];
      coord_type a, b;
      int        stored;
      int        pick;
      stored = 0;
      queue_word(OP_CLEAR, random_coord(), random_coord(), random_coord(),
                 random_coord(), random_coord(), random_coord());
      for (int i = 0; i < n_boxes; i++) begin
         for (int ax = 0; ax < 3; ax++) begin
            a = random_coord();
            b = random_coord();
            // Most boxes are ordered; a few are left inverted on purpose.
            if (a > b && $urandom_range(0, 7) != 0) begin
               lo_a[ax] = b;
               hi_a[ax] = a;
            end else begin
               lo_a[ax] = a;
               hi_a[ax] = b;
            end
         end
         if (stored < BOX_LIMIT) begin
            s_lo[stored] = lo_a;
            s_hi[stored] = hi_a;
            stored++;
         end
         queue_word(OP_APPEND, lo_a[0], lo_a[1], lo_a[2], hi_a[0], hi_a[1], hi_a[2]);
      end
      for (int j = 0; j < n_probes; j++) begin
         if ($urandom_range(0, 11) == 0)
            queue_word(2'($urandom_range(0, OP_SPARE)), random_coord(), random_coord(),
                       random_coord(), random_coord(), random_coord(), random_coord());
         if (stored != 0 && $urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, stored - 1);
            for (int ax = 0; ax < 3; ax++)
               pt[ax] = aim_axis(s_lo[pick][ax], s_hi[pick][ax], margin_now);
         end else begin
            for (int ax = 0; ax < 3; ax++)
               pt[ax] = random_coord();
         end
         queue_word(OP_CHECK, pt[0], pt[1], pt[2],
                    random_coord(), random_coord(), random_coord());
      end
   endtask

   // Waits until the block has answered everything, then writes the margin register.
   task automatic write_margin(input logic [MARGIN_W-1:0] value);
      while (pending_words.size() != 0 || expected_answers.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_safety_margin <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      margin_now = value;
      margins_written++;
      csr_valid <= 1'b0;
   endtask

   // Driver: holds a word until the block takes it, then offers the next one or idles.
   always @(posedge clock) begin : driver
      command_word_type taken;
      answer_type       verdict;
      logic             took;
      took = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            took = 1'b1;
            taken.op = req_operation;
            taken.lo_x = req_coord_x;
            taken.lo_y = req_coord_y;
            taken.lo_z = req_coord_z;
            taken.hi_x = req_upper_x;
            taken.hi_y = req_upper_y;
            taken.hi_z = req_upper_z;
            verdict = apply_word(taken);
            expected_answers.push_back(verdict);
            void'(pending_words.pop_front());
            words_sent++;
            case (taken.op)
               OP_CLEAR: clears_sent++;
               OP_APPEND: begin
                  appends_sent++;
                  if (verdict.status) full_refusals++;
               end
               OP_CHECK: begin
                  checks_sent++;
                  if (verdict.collides) hits_seen++;
               end
               default: spares_sent++;
            endcase
         end
         if (!start || took) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               start <= 1'b1;
               req_operation <= pending_words[0].op;
               req_coord_x <= pending_words[0].lo_x;
               req_coord_y <= pending_words[0].lo_y;
               req_coord_z <= pending_words[0].lo_z;
               req_upper_x <= pending_words[0].hi_x;
               req_upper_y <= pending_words[0].hi_y;
               req_upper_z <= pending_words[0].hi_z;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed answer must match the oldest outstanding expectation.
   always @(posedge clock) begin : monitor
      answer_type want;
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            $error("answer with no word outstanding: collides %0d, status %0d",
                   rsp_collides, rsp_status);
            mismatch_count++;
         end else begin
            want = expected_answers.pop_front();
            if (rsp_collides !== want.collides) begin
               $error("collides: expected %0d, actual %0d", want.collides, rsp_collides);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: ends the run when nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("point_vs_box_table_check_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [MARGIN_W-1:0] margin_pick;
      int                  roll;
      reset = 1'b1;
      start = 1'b0;
      req_operation = '0;
      req_coord_x = '0;
      req_coord_y = '0;
      req_coord_z = '0;
      req_upper_x = '0;
      req_upper_y = '0;
      req_upper_z = '0;
      csr_valid = 1'b0;
      csr_safety_margin = '0;
      shadow_count = 0;
      margin_now = '0;
      sender_idle_pct = 0;
      words_queued = 0;
      mismatch_count = 0;
      quiet_cycles = 0;
      margins_written = 0;
      words_sent = 0;
      checks_sent = 0;
      hits_seen = 0;
      appends_sent = 0;
      full_refusals = 0;
      clears_sent = 0;
      spares_sent = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Four phases: no idling, a sparse sender, no idling again, then light idling.
      // The margin runs through zero, its maximum, a small value and a random one.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: margin_pick = '0;
            1: margin_pick = '1;
            2: margin_pick = MARGIN_W'($urandom_range(0, 3 << 16));
            default: margin_pick = MARGIN_W'($urandom);
         endcase
         write_margin(margin_pick);
         case (phase)
            1: sender_idle_pct = 83;
            3: sender_idle_pct = 27;
            default: sender_idle_pct = 0;
         endcase
         @(negedge clock);
         words_queued = 0;

         if (phase == 0) begin
            // Empty table, unused code and the full coordinate range.
            queue_word(OP_CHECK, '0, '0, '0, '0, '0, '0);
            queue_word(OP_SPARE, '1, '1, '1, '1, '1, '1);
            queue_word(OP_CLEAR, MAX_COORD, MIN_COORD, '1, '0, MAX_COORD, MIN_COORD);
            queue_word(OP_APPEND, MIN_COORD, MIN_COORD, MIN_COORD,
                       MAX_COORD, MAX_COORD, MAX_COORD);
            queue_word(OP_CHECK, MIN_COORD, MIN_COORD, MIN_COORD, '1, '1, '1);
            queue_word(OP_CHECK, MAX_COORD, MAX_COORD, MAX_COORD, '0, '0, '0);
            queue_word(OP_CHECK, MIN_COORD, MAX_COORD, '0, '0, '0, '0);
            // Unit box around the origin: bounds are inclusive.
            queue_word(OP_CLEAR, '0, '0, '0, '0, '0, '0);
            queue_word(OP_APPEND, -UNIT, -UNIT, -UNIT, UNIT, UNIT, UNIT);
            queue_word(OP_CHECK, UNIT, UNIT, UNIT, '0, '0, '0);
            queue_word(OP_CHECK, UNIT + 1, '0, '0, '0, '0, '0);
            queue_word(OP_CHECK, '0, -UNIT, '0, '0, '0, '0);
            queue_word(OP_CHECK, '0, '0, -UNIT - 1, '0, '0, '0);
            // Inverted box on x contains nothing.
            queue_word(OP_APPEND, 5 * UNIT, '0, '0, 4 * UNIT, UNIT, UNIT);
            queue_word(OP_CHECK, coord_type'(32'sh0004_8000), UNIT >>> 1, UNIT >>> 1,
                       '0, '0, '0);
            queue_word(OP_SPARE, '0, '0, '0, '0, '0, '0);
            queue_word(OP_CHECK, '0, '0, '0, MIN_COORD, MIN_COORD, MIN_COORD);
            // A clear leaves an empty table behind.
            queue_word(OP_CLEAR, '0, '0, '0, '0, '0, '0);
            queue_word(OP_CHECK, '0, '0, '0, '0, '0, '0);
            // Fill the table past its capacity so appends get refused.
            queue_scene(BOX_LIMIT + 3, 6);
         end

         while (words_queued < PHASE_WORDS) begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
               queue_scene(0, $urandom_range(1, 4));
            else if (roll == 1)
               queue_scene($urandom_range(BOX_LIMIT - 4, BOX_LIMIT + 6), $urandom_range(1, 8));
            else if (roll < 5)
               queue_scene($urandom_range(9, 20), $urandom_range(1, 10));
            else
               queue_scene($urandom_range(1, 8), $urandom_range(1, 10));
         end
      end

      while (pending_words.size() != 0 || expected_answers.size() != 0)
         @(posedge clock);
      repeat (BOX_LIMIT + 8) @(posedge clock);

      $display("Sent %0d words: %0d checks (%0d hits), %0d appends (%0d refused as full),",
               words_sent, checks_sent, hits_seen, appends_sent, full_refusals);
      $display("%0d clears, %0d unused codes; margin register written %0d times.",
               clears_sent, spares_sent, margins_written);
      if (mismatch_count == 0)
         $display("point_vs_box_table_check_tb: done, clean");
      else
         $display("point_vs_box_table_check_tb: done, errors");
      $finish;
   end

endmodule
